>>> hdl/isu_pkg.sv
// Shared types and constants of the Ising Metropolis spin update core.
package isu_pkg;

    localparam int SITE_W   = 12;
    localparam int RAND_W   = 32;
    localparam int WORD_W   = 33;
    localparam int ACTION_W = 2;
    localparam int EIDX_W   = 3;
    localparam int TAP_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    localparam logic [WORD_W-1:0] ONE_WORD = 33'h1_0000_0000;

    localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ATTEMPT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROB_M4   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_M2   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_ZERO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_P2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_P4   = 3'd4;

    localparam logic [TAP_W-1:0] TAP_CENTRE = 3'd0;
    localparam logic [TAP_W-1:0] TAP_UP     = 3'd1;
    localparam logic [TAP_W-1:0] TAP_DOWN   = 3'd2;
    localparam logic [TAP_W-1:0] TAP_LEFT   = 3'd3;
    localparam logic [TAP_W-1:0] TAP_RIGHT  = 3'd4;

    localparam logic [EIDX_W-1:0] EIDX_MAX = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_EVAL
    } isu_state_t;

endpackage

>>> hdl/isu_cfg_regs.sv
// Acceptance word registers and lookup by energy index.
module isu_cfg_regs
    import isu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic [EIDX_W-1:0]    eidx,
    output logic [WORD_W-1:0]    prob_word
);

    logic [WORD_W-1:0] prob_m4_reg;
    logic [WORD_W-1:0] prob_m2_reg;
    logic [WORD_W-1:0] prob_zero_reg;
    logic [WORD_W-1:0] prob_p2_reg;
    logic [WORD_W-1:0] prob_p4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prob_m4_reg   <= ONE_WORD;
            prob_m2_reg   <= ONE_WORD;
            prob_zero_reg <= ONE_WORD;
            prob_p2_reg   <= ONE_WORD;
            prob_p4_reg   <= ONE_WORD;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PROB_M4:   prob_m4_reg   <= cfg_data;
                CFG_PROB_M2:   prob_m2_reg   <= cfg_data;
                CFG_PROB_ZERO: prob_zero_reg <= cfg_data;
                CFG_PROB_P2:   prob_p2_reg   <= cfg_data;
                CFG_PROB_P4:   prob_p4_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (eidx)
            CFG_PROB_M4:   prob_word = prob_m4_reg;
            CFG_PROB_M2:   prob_word = prob_m2_reg;
            CFG_PROB_ZERO: prob_word = prob_zero_reg;
            CFG_PROB_P2:   prob_word = prob_p2_reg;
            CFG_PROB_P4:   prob_word = prob_p4_reg;
            default:       prob_word = '0;
        endcase
    end

endmodule

>>> hdl/isu_spin_mem.sv
// One-bit spin memory, one write port and one registered read port.
module isu_spin_mem #(
    parameter int ADDR_BITS = 12
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic                 rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic                 wr_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic mem [0:DEPTH-1];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/isu_ctrl.sv
// Item sequencer: neighbour reads, Metropolis decision, write-back and result register.
module isu_ctrl
    import isu_pkg::*;
#(
    parameter int ROW_BITS = 6,
    parameter int COL_BITS = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ACTION_W-1:0]           s_action,
    input  logic [SITE_W-1:0]             s_site,
    input  logic                          s_spin_in,
    input  logic [RAND_W-1:0]             s_random_u,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          m_accepted,
    output logic                          m_spin_out,
    output logic [EIDX_W-1:0]             m_energy_index,
    output logic [EIDX_W-1:0]             eidx,
    input  logic [WORD_W-1:0]             prob_word,
    output logic                          rd_en,
    output logic [ROW_BITS+COL_BITS-1:0]  rd_addr,
    input  logic                          rd_data,
    output logic                          wr_en,
    output logic [ROW_BITS+COL_BITS-1:0]  wr_addr,
    output logic                          wr_data
);

    localparam int EXT_W = SITE_W + ROW_BITS + COL_BITS;

    isu_state_t state_reg, state_next;

    logic [TAP_W-1:0]    cnt_reg, cnt_next;
    logic                pend_reg;
    logic [TAP_W-1:0]    pend_tap_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [COL_BITS-1:0] col_reg;
    logic                spin_in_reg;
    logic [RAND_W-1:0]   rnd_reg;
    logic                centre_reg;
    logic [EIDX_W-1:0]   ups_reg;

    logic                m_tvalid_reg;
    logic                accepted_reg;
    logic                spin_out_reg;
    logic [EIDX_W-1:0]   eidx_out_reg;

    logic [EXT_W-1:0]    site_ext;
    logic                accept;
    logic                out_free;
    logic                done;
    logic                is_load;
    logic                is_attempt;
    logic                flip;
    logic [ROW_BITS-1:0] tap_row;
    logic [COL_BITS-1:0] tap_col;

    assign site_ext   = {{(ROW_BITS + COL_BITS){1'b0}}, s_site};
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign is_load    = (action_reg == ACT_LOAD);
    assign is_attempt = (action_reg == ACT_ATTEMPT);
    assign eidx       = centre_reg ? ups_reg : EIDX_MAX - ups_reg;
    assign flip       = is_attempt && (prob_word >= {1'b0, rnd_reg});

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = TAP_CENTRE;
                if (accept) begin
                    state_next = (s_action == ACT_LOAD) ? ST_EVAL : ST_READ;
                end
            end
            ST_READ: begin
                cnt_next = cnt_reg + TAP_W'(1);
                if (!is_attempt || cnt_reg == TAP_RIGHT) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: state_next = ST_EVAL;
            ST_EVAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        done     = 1'b0;
        tap_row  = row_reg;
        tap_col  = col_reg;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_READ: begin
                rd_en = 1'b1;
                case (cnt_reg)
                    TAP_UP:    tap_row = row_reg - ROW_BITS'(1);
                    TAP_DOWN:  tap_row = row_reg + ROW_BITS'(1);
                    TAP_LEFT:  tap_col = col_reg - COL_BITS'(1);
                    TAP_RIGHT: tap_col = col_reg + COL_BITS'(1);
                    default: ;
                endcase
            end
            ST_LAST: ;
            ST_EVAL: done = out_free;
            default: ;
        endcase
    end

    assign rd_addr = {tap_row, tap_col};
    assign wr_en   = done && (is_load || flip);
    assign wr_addr = {row_reg, col_reg};
    assign wr_data = is_load ? spin_in_reg : !centre_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= TAP_CENTRE;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= rd_en;
            if (done) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_tap_reg <= cnt_reg;
        if (accept) begin
            action_reg  <= s_action;
            row_reg     <= site_ext[COL_BITS +: ROW_BITS];
            col_reg     <= site_ext[COL_BITS-1:0];
            spin_in_reg <= s_spin_in;
            rnd_reg     <= s_random_u;
            ups_reg     <= '0;
            centre_reg  <= 1'b0;
        end else if (pend_reg) begin
            if (pend_tap_reg == TAP_CENTRE) begin
                centre_reg <= rd_data;
            end else begin
                ups_reg <= ups_reg + {{(EIDX_W-1){1'b0}}, rd_data};
            end
        end
        if (done) begin
            accepted_reg <= flip;
            spin_out_reg <= is_load ? spin_in_reg : (centre_reg ^ flip);
            eidx_out_reg <= is_attempt ? eidx : '0;
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign m_accepted     = accepted_reg;
    assign m_spin_out     = spin_out_reg;
    assign m_energy_index = eidx_out_reg;

endmodule

>>> hdl/ising_metropolis_spin_update_core.sv
// Metropolis spin update core for a 2D square Ising lattice with periodic wrap.
// Input stream (s_*): one item per handshake; s_tuser carries the action
// (load, attempt, read), s_tdata the site, the spin to load and the random word.
// Result stream (m_*): exactly one item per input item, in order.
// Config channel (cfg_*): writes the five acceptance words, 2^32 meaning 1.0;
// always ready, to be written only while the core is idle.
// Spins live in one memory of 2^(ROW_BITS+COL_BITS) bits with one registered
// read port, so an attempt reads its centre and four neighbours one per cycle.
// A load goes from acceptance straight to evaluation; a read reads its centre,
// an attempt its centre and four neighbours, and both then pass a last state
// before evaluation. The next item is taken in the cycle after the result is
// registered, at the same edge at which the result can first be taken.
// Reset clears control and sets every acceptance word to 2^32; spin contents
// are undefined until loaded, with no clearing pass.
// A stalled receiver holds the result in the output register; one further
// item is accepted and worked on, then the core waits before its write-back.
module ising_metropolis_spin_update_core
    import isu_pkg::*;
#(
    parameter int ROW_BITS = 6,
    parameter int COL_BITS = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // site[11:0], spin_in[12], random_u[44:13], zero[47:45]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // accepted[0], spin_out[1], energy_index[4:2], zero[7:5]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    localparam int ADDR_BITS = ROW_BITS + COL_BITS;

    logic [EIDX_W-1:0]    eidx;
    logic [WORD_W-1:0]    prob_word;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 rd_data;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic                 wr_data;
    logic                 m_accepted;
    logic                 m_spin_out;
    logic [EIDX_W-1:0]    m_energy_index;

    assign cfg_ready = 1'b1;

    isu_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eidx      (eidx),
        .prob_word (prob_word)
    );

    isu_spin_mem #(
        .ADDR_BITS (ADDR_BITS)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    isu_ctrl #(
        .ROW_BITS (ROW_BITS),
        .COL_BITS (COL_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_action       (s_tuser[ACTION_W-1:0]),
        .s_site         (s_tdata[SITE_W-1:0]),
        .s_spin_in      (s_tdata[SITE_W]),
        .s_random_u     (s_tdata[SITE_W+1 +: RAND_W]),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_accepted     (m_accepted),
        .m_spin_out     (m_spin_out),
        .m_energy_index (m_energy_index),
        .eidx           (eidx),
        .prob_word      (prob_word),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data)
    );

    assign m_tdata = {3'b000, m_energy_index, m_spin_out, m_accepted};

endmodule
